// ----- rtl/tsq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types and constants for the triangle / square overlap pipeline.
// ----------------------------------------------------------------------------
package tsq_pkg;

  localparam int NUM_VERTICES = 3;
  localparam int NUM_CORNERS  = 4;

  // sign summary of a wide signed value
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

// ----- rtl/tsq_corner_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_corner_lane
// One square corner against the triangle: forms the two barycentric
// numerators from registered products, then checks them and the remainder
// against the sign of the cross-product denominator.
// ----------------------------------------------------------------------------
module tsq_corner_lane #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic signed [2*COORD_WIDTH+2:0] den,
  input  logic signed [2*COORD_WIDTH+1:0] p_kx,
  input  logic signed [2*COORD_WIDTH+1:0] p_ky,
  input  logic signed [2*COORD_WIDTH+1:0] p_lx,
  input  logic signed [2*COORD_WIDTH+1:0] p_ly,
  output logic                           hit
);

  localparam int PW = 2 * (COORD_WIDTH + 1);
  localparam int KW = PW + 1;
  localparam int SW = KW + 1;
  localparam int RW = SW + 1;

  logic signed [KW-1:0] kn;
  logic signed [KW-1:0] ln;
  logic signed [SW-1:0] kl;
  logic signed [KW-1:0] den_d;
  tsq_pkg::sign_t       kn_sign;
  tsq_pkg::sign_t       ln_sign;
  logic signed [RW-1:0] rem;
  logic                 rem_neg;
  logic                 rem_zero;
  logic                 den_neg;
  logic                 den_zero;

  // numerators, aligned with den
  always_ff @(posedge clk) begin
    kn <= $signed({p_kx[PW-1], p_kx}) - $signed({p_ky[PW-1], p_ky});
    ln <= $signed({p_lx[PW-1], p_lx}) - $signed({p_ly[PW-1], p_ly});
  end

  always_ff @(posedge clk) begin
    kl           <= $signed({kn[KW-1], kn}) + $signed({ln[KW-1], ln});
    den_d        <= den;
    kn_sign.neg  <= kn[KW-1];
    kn_sign.zero <= (kn == '0);
    ln_sign.neg  <= ln[KW-1];
    ln_sign.zero <= (ln == '0);
  end

  always_comb begin
    rem      = $signed({{2{den_d[KW-1]}}, den_d}) - $signed({kl[SW-1], kl});
    rem_neg  = rem[RW-1];
    rem_zero = (rem == '0);
    den_neg  = den_d[KW-1];
    den_zero = (den_d == '0);
    if (den_zero) begin
      hit = 1'b0;
    end else if (!den_neg) begin
      hit = !kn_sign.neg && !ln_sign.neg && !rem_neg;
    end else begin
      hit = (kn_sign.neg || kn_sign.zero) && (ln_sign.neg || ln_sign.zero) &&
            (rem_neg || rem_zero);
    end
  end

endmodule

// ----- rtl/triangle_square_overlap_test.sv -----
`timescale 1ns / 1ps
// overlaps and done are both registered and change in the same cycle, after the start transfer
// throughput: one query per cycle; busy stays low, the five-stage pipeline never stalls
// stages: edge differences and square bounds, products, numerators, sums, final decision
// reset: synchronous rst clears the valid bits only; no result is pending afterwards
// the receiver cannot stall, so each result shows for exactly one cycle
// ----------------------------------------------------------------------------
// triangle_square_overlap_test
// Reports overlap when a triangle vertex lies in the square or a square
// corner lies in the triangle, boundaries inclusive.
// ----------------------------------------------------------------------------
module triangle_square_overlap_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] tri_a_x,
  input  logic signed [COORD_WIDTH-1:0] tri_a_y,
  input  logic signed [COORD_WIDTH-1:0] tri_b_x,
  input  logic signed [COORD_WIDTH-1:0] tri_b_y,
  input  logic signed [COORD_WIDTH-1:0] tri_c_x,
  input  logic signed [COORD_WIDTH-1:0] tri_c_y,
  input  logic signed [COORD_WIDTH-1:0] sq_min_x,
  input  logic signed [COORD_WIDTH-1:0] sq_min_y,
  input  logic signed [COORD_WIDTH-1:0] sq_max_x,
  input  logic signed [COORD_WIDTH-1:0] sq_max_y,
  output logic                          done,
  output logic                          overlaps
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int KW = PW + 1;

  // stage 1: differences and square test
  logic signed [DW-1:0] abx, aby, acx, acy;
  logic signed [DW-1:0] dx [2];
  logic signed [DW-1:0] dy [2];
  logic                 sq_hit1;
  logic                 v1;

  // stage 2: products
  logic signed [PW-1:0] den_p1, den_p2;
  logic signed [PW-1:0] p_acy_dx [2];
  logic signed [PW-1:0] p_aby_dx [2];
  logic signed [PW-1:0] p_acx_dy [2];
  logic signed [PW-1:0] p_abx_dy [2];
  logic                 sq_hit2;
  logic                 v2;

  // stage 3 and 4
  logic signed [KW-1:0] den3;
  logic                 sq_hit3, sq_hit4;
  logic                 v3, v4;

  logic [tsq_pkg::NUM_VERTICES-1:0] vert_in;
  logic [tsq_pkg::NUM_CORNERS-1:0]  corner_in;

  logic signed [W-1:0] vx [tsq_pkg::NUM_VERTICES];
  logic signed [W-1:0] vy [tsq_pkg::NUM_VERTICES];

  assign busy = 1'b0;

  assign vx[0] = tri_a_x;
  assign vy[0] = tri_a_y;
  assign vx[1] = tri_b_x;
  assign vy[1] = tri_b_y;
  assign vx[2] = tri_c_x;
  assign vy[2] = tri_c_y;

  always_comb begin
    for (int i = 0; i < tsq_pkg::NUM_VERTICES; i++) begin
      vert_in[i] = (sq_min_x <= vx[i]) && (vx[i] <= sq_max_x) &&
                   (sq_min_y <= vy[i]) && (vy[i] <= sq_max_y);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    abx     <= $signed({tri_b_x[W-1], tri_b_x}) - $signed({tri_a_x[W-1], tri_a_x});
    aby     <= $signed({tri_b_y[W-1], tri_b_y}) - $signed({tri_a_y[W-1], tri_a_y});
    acx     <= $signed({tri_c_x[W-1], tri_c_x}) - $signed({tri_a_x[W-1], tri_a_x});
    acy     <= $signed({tri_c_y[W-1], tri_c_y}) - $signed({tri_a_y[W-1], tri_a_y});
    dx[0]   <= $signed({sq_min_x[W-1], sq_min_x}) - $signed({tri_a_x[W-1], tri_a_x});
    dx[1]   <= $signed({sq_max_x[W-1], sq_max_x}) - $signed({tri_a_x[W-1], tri_a_x});
    dy[0]   <= $signed({sq_min_y[W-1], sq_min_y}) - $signed({tri_a_y[W-1], tri_a_y});
    dy[1]   <= $signed({sq_max_y[W-1], sq_max_y}) - $signed({tri_a_y[W-1], tri_a_y});
    sq_hit1 <= |vert_in;
  end

  always_ff @(posedge clk) begin
    den_p1 <= abx * acy;
    den_p2 <= aby * acx;
    for (int i = 0; i < 2; i++) begin
      p_acy_dx[i] <= acy * dx[i];
      p_aby_dx[i] <= aby * dx[i];
      p_acx_dy[i] <= acx * dy[i];
      p_abx_dy[i] <= abx * dy[i];
    end
    sq_hit2 <= sq_hit1;
  end

  always_ff @(posedge clk) begin
    den3    <= $signed({den_p1[PW-1], den_p1}) - $signed({den_p2[PW-1], den_p2});
    sq_hit3 <= sq_hit2;
    sq_hit4 <= sq_hit3;
  end

  // corner c takes x from bit 0 (min/max) and y from bit 1
  for (genvar c = 0; c < tsq_pkg::NUM_CORNERS; c++) begin : g_corner
    tsq_corner_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk (clk),
      .den (den3),
      .p_kx(p_acy_dx[c % 2]),
      .p_ky(p_acx_dy[c / 2]),
      .p_lx(p_abx_dy[c / 2]),
      .p_ly(p_aby_dx[c % 2]),
      .hit (corner_in[c])
    );
  end

  always_ff @(posedge clk) begin
    overlaps <= sq_hit4 || (|corner_in);
  end

  a_start_done : assert property (@(posedge clk) disable iff (rst)
    start |-> ##5 done)
    else $error("accepted query produced no result");

  a_done_start : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result without a matching query");

  a_vertex_hit : assert property (@(posedge clk) disable iff (rst)
    (done && $past(sq_hit1, 4)) |-> overlaps)
    else $error("vertex inside square not reported");

  a_degenerate : assert property (@(posedge clk) disable iff (rst)
    (done && $past(den3 == '0, 2) && !$past(sq_hit4, 1)) |-> !overlaps)
    else $error("degenerate triangle reported a corner inside");

endmodule
